@@ design/wsd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and codes for the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

  // Result kinds
  localparam logic [2:0] KIND_HEADER  = 3'd0;
  localparam logic [2:0] KIND_PAYLOAD = 3'd1;
  localparam logic [2:0] KIND_EMPTY   = 3'd2;
  localparam logic [2:0] KIND_ERROR   = 3'd3;
  localparam logic [2:0] KIND_DISCARD = 3'd4;

  // Error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_RESERVED = 2'd1;
  localparam logic [1:0] ERR_OPCODE   = 2'd2;
  localparam logic [1:0] ERR_UNMASKED = 2'd3;

  // Frame opcodes that are accepted
  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  // Length codes in the second header byte
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_stream;
  } wsd_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic [3:0] frame_opcode;
    logic       final_flag;
    logic       frame_end;
    logic [1:0] error_code;
  } wsd_result_t;

endpackage

@@ design/wsd_stream_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_in_if / wsd_out_if
// Valid/ready channels for incoming bytes and deframer results.
// ----------------------------------------------------------------------------
interface wsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       new_stream;

  modport source (output valid, output data_byte, output new_stream, input ready);
  modport sink   (input valid, input data_byte, input new_stream, output ready);
endinterface

interface wsd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] out_byte;
  logic [3:0] frame_opcode;
  logic       final_flag;
  logic       frame_end;
  logic [1:0] error_code;

  modport source (output valid, output kind, output out_byte, output frame_opcode,
                  output final_flag, output frame_end, output error_code, input ready);
  modport sink   (input valid, input kind, input out_byte, input frame_opcode,
                  input final_flag, input frame_end, input error_code, output ready);
endinterface

@@ design/wsd_in_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_in_stage
// Input register: holds one accepted byte until the parser consumes it.
// ----------------------------------------------------------------------------
module wsd_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  wsd_pkg::wsd_item_t in_item_i,
  output logic               valid_o,
  input  logic               take_i,
  output wsd_pkg::wsd_item_t item_o
);

  logic               valid_q, valid_d;
  wsd_pkg::wsd_item_t item_q;

  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ design/wsd_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_parser
// Frame state and per-byte parse/unmask logic; state advances on step_i.
// ----------------------------------------------------------------------------
module wsd_parser #(
  parameter int LENGTH_WIDTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  wsd_pkg::wsd_item_t   item_i,
  output wsd_pkg::wsd_result_t result_o
);

  localparam logic [2:0] PH_HDR1    = 3'd0;
  localparam logic [2:0] PH_HDR2    = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_MASK    = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  logic [2:0]              phase_q, phase_d, phase_c;
  logic                    stopped_q, stopped_d, stopped_c;
  logic [3:0]              opcode_q, opcode_d, opcode_c;
  logic                    fin_q, fin_d, fin_c;
  logic [LENGTH_WIDTH-1:0] len_q, len_d, len_c, len_dec;
  logic [2:0]              cnt_q, cnt_d, cnt_c;
  logic [31:0]             key_q, key_d, key_c;
  logic [1:0]              idx_q, idx_d, idx_c;
  logic [7:0]              b;
  logic [7:0]              key_byte;
  logic [1:0]              err;
  logic [2:0]              kind;
  logic [7:0]              ob;
  logic                    fend;

  assign b = item_i.data_byte;

  // New stream drops all state before the byte is parsed
  always_comb begin
    if (item_i.new_stream) begin
      phase_c   = PH_HDR1;
      stopped_c = 1'b0;
      opcode_c  = '0;
      fin_c     = 1'b0;
      len_c     = '0;
      cnt_c     = '0;
      key_c     = '0;
      idx_c     = '0;
    end else begin
      phase_c   = phase_q;
      stopped_c = stopped_q;
      opcode_c  = opcode_q;
      fin_c     = fin_q;
      len_c     = len_q;
      cnt_c     = cnt_q;
      key_c     = key_q;
      idx_c     = idx_q;
    end
  end

  assign len_dec = len_c - LENGTH_WIDTH'(1);

  always_comb begin
    case (idx_c)
      2'd0:    key_byte = key_c[31:24];
      2'd1:    key_byte = key_c[23:16];
      2'd2:    key_byte = key_c[15:8];
      default: key_byte = key_c[7:0];
    endcase
  end

  always_comb begin
    phase_d   = phase_c;
    stopped_d = stopped_c;
    opcode_d  = opcode_c;
    fin_d     = fin_c;
    len_d     = len_c;
    cnt_d     = cnt_c;
    key_d     = key_c;
    idx_d     = idx_c;
    kind      = wsd_pkg::KIND_HEADER;
    ob        = '0;
    fend      = 1'b0;
    err       = wsd_pkg::ERR_NONE;

    if (stopped_c) begin
      kind = wsd_pkg::KIND_DISCARD;
    end else begin
      case (phase_c)
        PH_HDR2: begin
          if (!b[7]) begin
            err = wsd_pkg::ERR_UNMASKED;
          end else begin
            len_d = '0;
            key_d = '0;
            idx_d = '0;
            if (b[6:0] == wsd_pkg::LEN_EXT16) begin
              cnt_d   = 3'd1;
              phase_d = PH_EXTLEN;
            end else if (b[6:0] == wsd_pkg::LEN_EXT64) begin
              cnt_d   = 3'd7;
              phase_d = PH_EXTLEN;
            end else begin
              len_d   = LENGTH_WIDTH'(b[6:0]);
              cnt_d   = 3'd3;
              phase_d = PH_MASK;
            end
          end
        end
        PH_EXTLEN: begin
          // big-endian shift-in; high bytes fall off past the register width
          len_d = {len_c[LENGTH_WIDTH-9:0], b};
          if (cnt_c == 3'd0) begin
            cnt_d   = 3'd3;
            phase_d = PH_MASK;
          end else begin
            cnt_d = cnt_c - 3'd1;
          end
        end
        PH_MASK: begin
          key_d = {key_c[23:0], b};
          if (cnt_c == 3'd0) begin
            idx_d = '0;
            if (len_c == '0) begin
              kind    = wsd_pkg::KIND_EMPTY;
              fend    = 1'b1;
              phase_d = PH_HDR1;
            end else begin
              phase_d = PH_PAYLOAD;
            end
          end else begin
            cnt_d = cnt_c - 3'd1;
          end
        end
        PH_PAYLOAD: begin
          kind  = wsd_pkg::KIND_PAYLOAD;
          ob    = b ^ key_byte;
          idx_d = idx_c + 2'd1;
          len_d = len_dec;
          if (len_dec == '0) begin
            fend    = 1'b1;
            phase_d = PH_HDR1;
          end
        end
        default: begin
          fin_d    = b[7];
          opcode_d = b[3:0];
          if (|b[6:4]) begin
            err = wsd_pkg::ERR_RESERVED;
          end else if (!(b[3:0] inside {[wsd_pkg::OP_CONT:wsd_pkg::OP_BINARY],
                                        [wsd_pkg::OP_CLOSE:wsd_pkg::OP_PONG]})) begin
            err = wsd_pkg::ERR_OPCODE;
          end else begin
            phase_d = PH_HDR2;
          end
        end
      endcase
      if (err != wsd_pkg::ERR_NONE) begin
        kind      = wsd_pkg::KIND_ERROR;
        stopped_d = 1'b1;
        phase_d   = PH_HDR1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HDR1;
      stopped_q <= 1'b0;
      opcode_q  <= '0;
      fin_q     <= 1'b0;
      len_q     <= '0;
      cnt_q     <= '0;
      key_q     <= '0;
      idx_q     <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      stopped_q <= stopped_d;
      opcode_q  <= opcode_d;
      fin_q     <= fin_d;
      len_q     <= len_d;
      cnt_q     <= cnt_d;
      key_q     <= key_d;
      idx_q     <= idx_d;
    end
  end

  assign result_o.kind         = kind;
  assign result_o.out_byte     = ob;
  assign result_o.frame_opcode = opcode_d;
  assign result_o.final_flag   = fin_d;
  assign result_o.frame_end    = fend;
  assign result_o.error_code   = err;

endmodule

@@ design/wsd_out_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_out_stage
// Result register: holds one result until the sink takes it.
// ----------------------------------------------------------------------------
module wsd_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  wsd_pkg::wsd_result_t result_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output wsd_pkg::wsd_result_t result_o
);

  logic                 valid_q, valid_d;
  wsd_pkg::wsd_result_t result_q;

  assign ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

@@ design/websocket_frame_deframer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Client-to-server WebSocket frame parser with payload unmasking.
// Each byte goes through the input register, the parse logic and the result
// register. Throughput: one byte per cycle while the sink takes results,
// one result per byte.
// Reset clears the frame state and both stage valids; first header expected.
// ----------------------------------------------------------------------------
module websocket_frame_deframer #(
  parameter int LENGTH_WIDTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  wsd_in_if.sink           in_i,
  wsd_out_if.source        out_o
);

  wsd_pkg::wsd_item_t   in_item;
  wsd_pkg::wsd_item_t   stage_item;
  wsd_pkg::wsd_result_t parse_result;
  wsd_pkg::wsd_result_t out_result;
  logic                 stage_valid;
  logic                 out_stage_ready;
  logic                 step;
  logic                 in_ready;
  logic                 out_valid;

  assign in_item.data_byte  = in_i.data_byte;
  assign in_item.new_stream = in_i.new_stream;
  assign in_i.ready         = in_ready;

  assign step = stage_valid && out_stage_ready;

  wsd_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .valid_o    (stage_valid),
    .take_i     (step),
    .item_o     (stage_item)
  );

  wsd_parser #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (stage_item),
    .result_o (parse_result)
  );

  wsd_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (stage_valid),
    .ready_o     (out_stage_ready),
    .result_i    (parse_result),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .result_o    (out_result)
  );

  assign out_o.valid        = out_valid;
  assign out_o.kind         = out_result.kind;
  assign out_o.out_byte     = out_result.out_byte;
  assign out_o.frame_opcode = out_result.frame_opcode;
  assign out_o.final_flag   = out_result.final_flag;
  assign out_o.frame_end    = out_result.frame_end;
  assign out_o.error_code   = out_result.error_code;

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the WebSocket frame deframer. Builds client frame
// byte streams (short, 16-bit and 64-bit lengths, empty frames, protocol
// errors, aborted frames, noise), pushes them through the byte channel with
// random source gaps and sink stalls, and checks every result transaction
// against an in-bench model of the parser.
// ----------------------------------------------------------------------------
module testbench;

  localparam int LEN_W      = 64;
  localparam int IDLE_LIMIT = 2000;
  localparam int CALM_TAIL  = 40;

  // Length encodings used by the frame builder
  localparam int FORM_SHORT = 0;
  localparam int FORM_EXT16 = 1;
  localparam int FORM_EXT64 = 2;

  typedef enum logic [2:0] {
    ST_HEAD0, ST_HEAD1, ST_EXTLEN, ST_KEY, ST_DATA
  } parse_state_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  wsd_in_if  in_if ();
  wsd_out_if out_if ();

  websocket_frame_deframer #(
    .LENGTH_WIDTH(LEN_W)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #5 clk_i = ~clk_i;

  wsd_pkg::wsd_item_t   wire_bytes_q[$];
  wsd_pkg::wsd_result_t frame_results_q[$];

  int   mismatch_count = 0;
  int   idle_cycles    = 0;
  int   src_gap        = 0;
  int   snk_gap        = 0;
  logic byte_taken     = 1'b0;

  // Parser model state
  parse_state_e     stage     = ST_HEAD0;
  logic             halted    = 1'b0;
  logic [3:0]       cur_op    = 4'h0;
  logic             cur_fin   = 1'b0;
  logic [LEN_W-1:0] remaining = '0;
  logic [2:0]       count     = 3'd0;
  logic [31:0]      key       = 32'h0;
  logic [1:0]       key_idx   = 2'd0;

  function automatic logic opcode_valid(input logic [3:0] op);
    return op <= wsd_pkg::OP_BINARY || (op >= wsd_pkg::OP_CLOSE && op <= wsd_pkg::OP_PONG);
  endfunction

  function automatic wsd_pkg::wsd_result_t deframe_byte(input logic [7:0] b, input logic ns);
    wsd_pkg::wsd_result_t r;
    logic [1:0]           err;
    r   = '0;
    err = wsd_pkg::ERR_NONE;
    r.kind = wsd_pkg::KIND_HEADER;
    if (ns) begin
      stage   = ST_HEAD0;
      halted  = 1'b0;
      cur_op  = 4'h0;
      cur_fin = 1'b0;
      remaining = '0;
      count   = 3'd0;
      key     = 32'h0;
      key_idx = 2'd0;
    end
    if (halted) begin
      r.kind = wsd_pkg::KIND_DISCARD;
    end else begin
      case (stage)
        ST_HEAD1: begin
          if (!b[7]) begin
            err = wsd_pkg::ERR_UNMASKED;
          end else begin
            remaining = '0;
            key       = 32'h0;
            key_idx   = 2'd0;
            if (b[6:0] == wsd_pkg::LEN_EXT16) begin
              count = 3'd1;
              stage = ST_EXTLEN;
            end else if (b[6:0] == wsd_pkg::LEN_EXT64) begin
              count = 3'd7;
              stage = ST_EXTLEN;
            end else begin
              remaining = LEN_W'(b[6:0]);
              count     = 3'd3;
              stage     = ST_KEY;
            end
          end
        end
        ST_EXTLEN: begin
          remaining = (remaining << 8) | LEN_W'(b);
          if (count == 3'd0) begin
            count = 3'd3;
            stage = ST_KEY;
          end else begin
            count = count - 3'd1;
          end
        end
        ST_KEY: begin
          key = {key[23:0], b};
          if (count == 3'd0) begin
            key_idx = 2'd0;
            if (remaining == '0) begin
              r.kind      = wsd_pkg::KIND_EMPTY;
              r.frame_end = 1'b1;
              stage       = ST_HEAD0;
            end else begin
              stage = ST_DATA;
            end
          end else begin
            count = count - 3'd1;
          end
        end
        ST_DATA: begin
          r.kind     = wsd_pkg::KIND_PAYLOAD;
          // key byte 0 is the first one received, i.e. the top byte
          r.out_byte = b ^ key[31 - 8 * int'(key_idx) -: 8];
          key_idx    = key_idx + 2'd1;
          remaining  = remaining - LEN_W'(1);
          if (remaining == '0) begin
            r.frame_end = 1'b1;
            stage       = ST_HEAD0;
          end
        end
        default: begin
          cur_fin = b[7];
          cur_op  = b[3:0];
          if (b[6:4] != 3'b000) begin
            err = wsd_pkg::ERR_RESERVED;
          end else if (!opcode_valid(b[3:0])) begin
            err = wsd_pkg::ERR_OPCODE;
          end else begin
            stage = ST_HEAD1;
          end
        end
      endcase
      if (err != wsd_pkg::ERR_NONE) begin
        r.kind = wsd_pkg::KIND_ERROR;
        halted = 1'b1;
        stage  = ST_HEAD0;
      end
    end
    r.frame_opcode = cur_op;
    r.final_flag   = cur_fin;
    r.error_code   = err;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stream builders
  // --------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b, input logic ns);
    wire_bytes_q.push_back({b, ns});
  endtask

  task automatic push_frame(input logic ns, input logic fin, input logic [3:0] op,
                            input int form, input logic [63:0] len,
                            input logic [31:0] mkey, input int n_data);
    int i;
    push_byte({fin, 3'b000, op}, ns);
    case (form)
      FORM_SHORT: push_byte({1'b1, len[6:0]}, 1'b0);
      FORM_EXT16: begin
        push_byte({1'b1, wsd_pkg::LEN_EXT16}, 1'b0);
        push_byte(len[15:8], 1'b0);
        push_byte(len[7:0], 1'b0);
      end
      default: begin
        push_byte({1'b1, wsd_pkg::LEN_EXT64}, 1'b0);
        for (i = 7; i >= 0; i--) push_byte(len[8*i +: 8], 1'b0);
      end
    endcase
    for (i = 3; i >= 0; i--) push_byte(mkey[8*i +: 8], 1'b0);
    for (i = 0; i < n_data; i++) push_byte(8'($urandom), 1'b0);
  endtask

  function automatic logic [3:0] pick_opcode();
    case ($urandom_range(0, 5))
      0:       return wsd_pkg::OP_CONT;
      1:       return wsd_pkg::OP_TEXT;
      2:       return wsd_pkg::OP_BINARY;
      3:       return wsd_pkg::OP_CLOSE;
      4:       return wsd_pkg::OP_PING;
      default: return wsd_pkg::OP_PONG;
    endcase
  endfunction

  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic build_stream();
    int          sel;
    int          form;
    int          n;
    int          i;
    logic        restart;
    logic [63:0] len;
    restart = 1'b0;

    // Directed: empty frame, 16-bit length, reserved bits then discard,
    // bad opcode, unmasked frame.
    push_frame(1'b1, 1'b1, wsd_pkg::OP_PING, FORM_SHORT, 64'd0, 32'h0000_0000, 0);
    push_frame(1'b0, 1'b0, wsd_pkg::OP_BINARY, FORM_EXT16, 64'd2, 32'hFFFF_FFFF, 2);
    push_byte(8'h7F, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte({1'b1, 3'b000, 4'h3}, 1'b1);
    push_byte({1'b1, 3'b000, wsd_pkg::OP_CONT}, 1'b1);
    push_byte(8'h05, 1'b0);
    restart = 1'b1;

    while (wire_bytes_q.size() < 470) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        form = $urandom_range(0, 9);
        if (form < 6) begin
          form = FORM_SHORT;
          len  = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(0, 125))
                                             : 64'($urandom_range(0, 12));
        end else if (form < 8) begin
          form = FORM_EXT16;
          len  = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(0, 200))
                                             : 64'($urandom_range(0, 20));
        end else begin
          form = FORM_EXT64;
          len  = 64'($urandom_range(0, 20));
        end
        push_frame(restart || ($urandom_range(0, 4) == 0), 1'($urandom), pick_opcode(),
                   form, len, pick_key(), int'(len));
        restart = 1'b0;
      end else if (sel < 78) begin
        // bad first header byte, then some bytes that should be dropped
        if ($urandom_range(0, 1) != 0)
          push_byte({1'($urandom), 3'($urandom_range(1, 7)), 4'($urandom)}, restart);
        else if ($urandom_range(0, 1) != 0)
          push_byte({1'($urandom), 3'b000, 4'($urandom_range(3, 7))}, restart);
        else
          push_byte({1'($urandom), 3'b000, 4'($urandom_range(11, 15))}, restart);
        n = $urandom_range(0, 3);
        for (i = 0; i < n; i++) push_byte(8'($urandom), 1'b0);
        restart = 1'b1;
      end else if (sel < 84) begin
        push_byte({1'($urandom), 3'b000, pick_opcode()}, restart);
        push_byte({1'b0, 7'($urandom)}, 1'b0);
        restart = 1'b1;
      end else if (sel < 92) begin
        // frame cut short by a new stream; large lengths, some at the field extremes
        form = ($urandom_range(0, 1) != 0) ? FORM_EXT16 : FORM_EXT64;
        case ($urandom_range(0, 2))
          0:       len = 64'hFFFF_FFFF_FFFF_FFFF;
          1:       len = {$urandom, $urandom} | 64'h100;
          default: len = 64'h8000_0000_0000_0000;
        endcase
        if (form == FORM_EXT16) len[63:16] = '0;
        push_frame(restart, 1'($urandom), pick_opcode(), form, len, pick_key(),
                   $urandom_range(0, 6));
        restart = 1'b1;
      end else begin
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++) push_byte(8'($urandom), 1'b0);
        restart = 1'b1;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Byte driver
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive_bytes
    logic               nxt_valid;
    wsd_pkg::wsd_item_t item;
    if (rst_ni) begin
      nxt_valid = in_if.valid && !byte_taken;
      if (!nxt_valid) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (wire_bytes_q.size() > 0) begin
          item = wire_bytes_q.pop_front();
          nxt_valid = 1'b1;
          in_if.data_byte  <= item.data_byte;
          in_if.new_stream <= item.new_stream;
          if (wire_bytes_q.size() >= CALM_TAIL && $urandom_range(0, 9) == 0)
            src_gap = $urandom_range(1, 17);
        end
      end
      in_if.valid <= nxt_valid;
    end
  end

  // Result sink backpressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (snk_gap > 0) begin
        snk_gap--;
        out_if.ready <= 1'b0;
      end else if (wire_bytes_q.size() >= CALM_TAIL && $urandom_range(0, 11) == 0) begin
        snk_gap = $urandom_range(1, 17) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor, checker and watchdog
  // --------------------------------------------------------------------------
  task automatic report_field(input string field, input logic [7:0] want,
                              input logic [7:0] got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin : check_results
    wsd_pkg::wsd_result_t want;
    wsd_pkg::wsd_result_t got;
    logic                 result_taken;
    byte_taken   = in_if.valid && in_if.ready;
    result_taken = out_if.valid && out_if.ready;
    if (byte_taken)
      frame_results_q.push_back(deframe_byte(in_if.data_byte, in_if.new_stream));
    if (result_taken) begin
      got.kind         = out_if.kind;
      got.out_byte     = out_if.out_byte;
      got.frame_opcode = out_if.frame_opcode;
      got.final_flag   = out_if.final_flag;
      got.frame_end    = out_if.frame_end;
      got.error_code   = out_if.error_code;
      if (frame_results_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, got);
        mismatch_count++;
      end else begin
        want = frame_results_q.pop_front();
        if (got.kind !== want.kind)
          report_field("kind", 8'(want.kind), 8'(got.kind));
        if (got.out_byte !== want.out_byte)
          report_field("out_byte", want.out_byte, got.out_byte);
        if (got.frame_opcode !== want.frame_opcode)
          report_field("frame_opcode", 8'(want.frame_opcode), 8'(got.frame_opcode));
        if (got.final_flag !== want.final_flag)
          report_field("final_flag", 8'(want.final_flag), 8'(got.final_flag));
        if (got.frame_end !== want.frame_end)
          report_field("frame_end", 8'(want.frame_end), 8'(got.frame_end));
        if (got.error_code !== want.error_code)
          report_field("error_code", 8'(want.error_code), 8'(got.error_code));
      end
    end
    if (byte_taken || result_taken) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: timeout, %0d results outstanding", $time, frame_results_q.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.data_byte  = 8'h00;
    in_if.new_stream = 1'b0;
    out_if.ready     = 1'b0;
    build_stream();
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (wire_bytes_q.size() != 0 || in_if.valid) @(negedge clk_i);
    while (frame_results_q.size() != 0) @(negedge clk_i);
    // two-stage pipeline; let any stray result show up
    repeat (8) @(negedge clk_i);

    if (mismatch_count == 0 && frame_results_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
